### rtl/core/tofc_pkg.sv
// Package for the time-of-flight UART frame checker.
// Holds the frame constants, status codes and the result struct. No dependencies.
package tofc_pkg;

  localparam int unsigned FrameBytes = 16;
  localparam int unsigned PosWidth   = 4;

  localparam logic [PosWidth-1:0] PosHdr0   = 4'd0;
  localparam logic [PosWidth-1:0] PosHdr1   = 4'd1;
  localparam logic [PosWidth-1:0] PosHdr2   = 4'd2;
  localparam logic [PosWidth-1:0] PosDist0  = 4'd8;
  localparam logic [PosWidth-1:0] PosDist1  = 4'd9;
  localparam logic [PosWidth-1:0] PosDist2  = 4'd10;
  localparam logic [PosWidth-1:0] PosStr0   = 4'd12;
  localparam logic [PosWidth-1:0] PosStr1   = 4'd13;
  localparam logic [PosWidth-1:0] PosLast   = PosWidth'(FrameBytes - 1);

  localparam logic [7:0]  Hdr0       = 8'h57;
  localparam logic [7:0]  Hdr1       = 8'h00;
  localparam logic [7:0]  Hdr2       = 8'hFF;
  localparam logic [23:0] OutOfRange = 24'hFFFFF6;

  typedef enum logic [1:0] {
    STATUS_VALID     = 2'd0,
    STATUS_BAD_FRAME = 2'd1,
    STATUS_NO_SIGNAL = 2'd2
  } frame_status_t;

  typedef struct packed {
    frame_status_t status;
    logic [23:0]   distance;
    logic [15:0]   strength;
  } frame_result_t;

endpackage

### rtl/core/tofc_in_reg.sv
// Input register for received bytes of the frame checker.
// Depends on nothing but the clock and reset.
module tofc_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  output logic       held_valid,
  output logic [7:0] held_byte,
  input  logic       held_take
);

  logic       valid;
  logic       valid_next;
  logic [7:0] data;

  // The register refills in the same cycle that its item moves on.
  assign rx_ready   = !valid || held_take;
  assign valid_next = (rx_valid && rx_ready) || (valid && !held_take);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) begin
      data <= rx_byte;
    end
  end

  assign held_valid = valid;
  assign held_byte  = data;

endmodule

### rtl/core/tofc_frame_acc.sv
// Frame accumulator: byte position, running sum, header flag and field captures.
// Uses tofc_pkg for frame constants and the result struct.
module tofc_frame_acc (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  logic [7:0]             data,
  output logic                   is_last,
  output tofc_pkg::frame_result_t result
);
  import tofc_pkg::*;

  logic [PosWidth-1:0] pos;
  logic [PosWidth-1:0] pos_next;
  logic [7:0]          running_sum;
  logic [7:0]          running_sum_next;
  logic                header_match;
  logic                header_match_next;
  logic [23:0]         distance_capture;
  logic [23:0]         distance_capture_next;
  logic [15:0]         strength_capture;
  logic [15:0]         strength_capture_next;

  assign is_last = (pos == PosLast);

  always_comb begin
    header_match_next     = header_match;
    distance_capture_next = distance_capture;
    strength_capture_next = strength_capture;
    case (pos)
      PosHdr0:  header_match_next = header_match && (data == Hdr0);
      PosHdr1:  header_match_next = header_match && (data == Hdr1);
      PosHdr2:  header_match_next = header_match && (data == Hdr2);
      PosDist0: distance_capture_next[7:0]   = data;
      PosDist1: distance_capture_next[15:8]  = data;
      PosDist2: distance_capture_next[23:16] = data;
      PosStr0:  strength_capture_next[7:0]   = data;
      PosStr1:  strength_capture_next[15:8]  = data;
      default:  ;
    endcase
    if (is_last) begin
      // The last byte closes the frame and restarts the header and sum.
      pos_next          = '0;
      running_sum_next  = '0;
      header_match_next = 1'b1;
    end else begin
      pos_next         = pos + 1'b1;
      running_sum_next = running_sum + data;
    end
  end

  always_comb begin
    result.distance = distance_capture;
    result.strength = strength_capture;
    if (!header_match || (running_sum != data)) begin
      result.status = STATUS_BAD_FRAME;
    end else if ((strength_capture == '0) || (distance_capture == OutOfRange)) begin
      result.status = STATUS_NO_SIGNAL;
    end else begin
      result.status = STATUS_VALID;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos              <= '0;
      running_sum      <= '0;
      header_match     <= 1'b1;
      distance_capture <= '0;
      strength_capture <= '0;
    end else if (take) begin
      pos              <= pos_next;
      running_sum      <= running_sum_next;
      header_match     <= header_match_next;
      distance_capture <= distance_capture_next;
      strength_capture <= strength_capture_next;
    end
  end

endmodule

### rtl/core/tofc_out_reg.sv
// Result register of the frame checker, holding one finished frame result.
// Uses tofc_pkg for the result struct.
module tofc_out_reg (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  tofc_pkg::frame_result_t load_data,
  output logic                    slot_free,
  output logic                    res_valid,
  input  logic                    res_ready,
  output tofc_pkg::frame_result_t held
);
  import tofc_pkg::*;

  logic          valid;
  logic          valid_next;
  frame_result_t data;

  assign slot_free  = !valid || res_ready;
  assign valid_next = load || (valid && !res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

  assign res_valid = valid;
  assign held      = data;

endmodule

### rtl/core/tof_uart_frame_checker_top.sv
// Time-of-flight UART frame checker, top level.
// Each byte passes through the input register; a frame's result is loaded into the
// result register when its 16th byte leaves. Throughput: one byte per cycle, and
// bytes flow unbroken unless a last byte waits for the result register to free up.
// Reset (rst, synchronous, active high) empties both registers and restarts the
// frame count at byte 0 with a cleared sum and distance and strength captures.
module tof_uart_frame_checker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_ready,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [1:0]  frame_status,
  output logic [23:0] distance_mm,
  output logic [15:0] signal_strength
);
  import tofc_pkg::*;

  logic          held_valid;
  logic [7:0]    held_byte;
  logic          held_take;
  logic          is_last;
  logic          slot_free;
  logic          result_load;
  frame_result_t frame_result;
  frame_result_t out_data;

  // Each accepted byte is first parked in the input register.
  tofc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_ready   (rx_ready),
    .rx_byte    (rx_byte),
    .held_valid (held_valid),
    .held_byte  (held_byte),
    .held_take  (held_take)
  );

  // A held byte moves into the frame state at once, unless it is the last
  // byte of a frame and the result register still holds an untaken result.
  assign held_take   = held_valid && (!is_last || slot_free);
  assign result_load = held_take && is_last;

  tofc_frame_acc u_frame_acc (
    .clk     (clk),
    .rst     (rst),
    .take    (held_take),
    .data    (held_byte),
    .is_last (is_last),
    .result  (frame_result)
  );

  // The result register separates the two sides so that bytes keep flowing
  // while a finished result waits to be taken.
  tofc_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (result_load),
    .load_data (frame_result),
    .slot_free (slot_free),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .held      (out_data)
  );

  assign frame_status    = out_data.status;
  assign distance_mm     = out_data.distance;
  assign signal_strength = out_data.strength;

  // A result can only be loaded into a free result register.
  assert property (@(posedge clk) disable iff (rst)
    result_load |-> slot_free)
    else $error("frame result loaded over an untaken result");

  // A new result shows up only after a last byte was processed.
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && !$past(res_valid && !res_ready)) |-> $past(result_load))
    else $error("result appeared without a completed frame");

  // The input register never takes a byte while it still holds one that stays.
  assert property (@(posedge clk) disable iff (rst)
    (held_valid && !held_take) |-> !rx_ready)
    else $error("input register overwritten");

  // Status code three is never produced.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (frame_status != 2'd3))
    else $error("illegal frame status");

endmodule

### tb/tof_uart_frame_checker_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the time-of-flight UART frame checker top level.
// Streams directed and random 16-byte frames and checks every frame result.
// Depends on tofc_pkg and tof_uart_frame_checker_top.
module tof_uart_frame_checker_top_tb;
  import tofc_pkg::*;

  // The longest legal stretch without any item moving is the receiver hold-off
  // below plus a few short random stalls, so the watchdog allows many times that.
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned PhaseBytes = 112;
  localparam int NoFault = -1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        rx_valid = 1'b0;
  logic        rx_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        res_valid;
  logic        res_ready = 1'b0;
  logic [1:0]  frame_status;
  logic [23:0] distance_mm;
  logic [15:0] signal_strength;

  tof_uart_frame_checker_top uut (
    .clk             (clk),
    .rst             (rst),
    .rx_valid        (rx_valid),
    .rx_ready        (rx_ready),
    .rx_byte         (rx_byte),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .frame_status    (frame_status),
    .distance_mm     (distance_mm),
    .signal_strength (signal_strength)
  );

  always #6 clk = ~clk;

  // Bytes waiting to be offered to the block, filled by the stimulus process.
  logic [7:0] pending_bytes [$];
  // Frame results the block still owes us, oldest first.
  frame_result_t frame_expect [$];

  // Idle rates of the sending and the receiving side, in percent.
  int unsigned feed_idle_pct = 24;
  int unsigned drain_idle_pct = 52;

  // One long receiver hold-off is requested by the stimulus process and
  // counted out by the receiver process itself.
  logic        hold_start = 1'b0;
  logic        hold_done;
  int unsigned hold_left;

  int unsigned mismatch_count = 0;
  int unsigned stall_cycles;
  int unsigned bytes_queued = 0;

  // Our own copy of the frame state, advanced once per accepted byte.
  logic [3:0]  frame_pos = '0;
  logic [7:0]  frame_sum = '0;
  logic        hdr_ok = 1'b1;
  logic [23:0] dist_cap = '0;
  logic [15:0] str_cap = '0;

  // Advances the frame state by one byte. The block does not hunt for the
  // header: byte 0 is just the byte after the last frame's checksum byte.
  // On the checksum byte the result is worked out and queued. An error on the
  // header or checksum wins over a weak signal or an out-of-range distance,
  // and the captured distance and strength are reported whatever the status.
  task automatic absorb_byte(input logic [7:0] b);
    frame_result_t r;
    case (frame_pos)
      PosHdr0: if (b != Hdr0) hdr_ok = 1'b0;
      PosHdr1: if (b != Hdr1) hdr_ok = 1'b0;
      PosHdr2: if (b != Hdr2) hdr_ok = 1'b0;
      PosDist0: dist_cap[7:0] = b;
      PosDist1: dist_cap[15:8] = b;
      PosDist2: dist_cap[23:16] = b;
      PosStr0: str_cap[7:0] = b;
      PosStr1: str_cap[15:8] = b;
      default: ;
    endcase
    if (frame_pos != PosLast) begin
      frame_sum = frame_sum + b;
      frame_pos = frame_pos + 4'd1;
    end else begin
      if (!hdr_ok || frame_sum != b) begin
        r.status = STATUS_BAD_FRAME;
      end else if (str_cap == '0 || dist_cap == OutOfRange) begin
        r.status = STATUS_NO_SIGNAL;
      end else begin
        r.status = STATUS_VALID;
      end
      r.distance = dist_cap;
      r.strength = str_cap;
      frame_expect.push_back(r);
      frame_pos = '0;
      frame_sum = '0;
      hdr_ok = 1'b1;
    end
  endtask

  // Queues one frame with a proper header and checksum, then spoils the
  // header byte at hdr_fault (if any) and the checksum (if sum_fault).
  // The padding bytes carry random content.
  task automatic queue_frame(input logic [23:0] range_val, input logic [15:0] str,
                             input int hdr_fault, input bit sum_fault);
    logic [7:0] fb [16];
    logic [7:0] sum;
    sum = '0;
    for (int i = 0; i < 16; i++) fb[i] = 8'($urandom);
    fb[0] = Hdr0;
    fb[1] = Hdr1;
    fb[2] = Hdr2;
    fb[8] = range_val[7:0];
    fb[9] = range_val[15:8];
    fb[10] = range_val[23:16];
    fb[12] = str[7:0];
    fb[13] = str[15:8];
    if (hdr_fault >= 0) fb[hdr_fault] = fb[hdr_fault] ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < 15; i++) sum = sum + fb[i];
    fb[15] = sum_fault ? sum + 8'($urandom_range(1, 255)) : sum;
    for (int i = 0; i < 16; i++) pending_bytes.push_back(fb[i]);
    bytes_queued += 16;
  endtask

  task automatic queue_fill(input logic [7:0] b, input int n);
    for (int i = 0; i < n; i++) pending_bytes.push_back(b);
    bytes_queued += n;
  endtask

  task automatic queue_noise(input int n);
    for (int i = 0; i < n; i++) pending_bytes.push_back(8'($urandom));
    bytes_queued += n;
  endtask

  // Random frames until about n more bytes are queued. Most frames are well
  // formed with random distance and strength, edge values included; the rest
  // are broken headers, bad checksums, pure noise, or a slip out of frame
  // alignment that is later repaired by topping the stream up to 16 bytes.
  task automatic queue_random_frames(input int unsigned n);
    int unsigned stop_at;
    int unsigned kind;
    int unsigned slip;
    logic [23:0] range_val;
    logic [15:0] str;
    stop_at = bytes_queued + n;
    while (bytes_queued < stop_at) begin
      kind = $urandom_range(99);
      range_val = 24'($urandom);
      str = 16'($urandom);
      case ($urandom_range(19))
        0, 1: range_val = OutOfRange;
        2: range_val = '0;
        3: range_val = '1;
        default: ;
      endcase
      case ($urandom_range(19))
        0, 1: str = '0;
        2: str = '1;
        default: ;
      endcase
      if (kind < 70) begin
        queue_frame(range_val, str, NoFault, $urandom_range(9) == 0);
      end else if (kind < 80) begin
        queue_frame(range_val, str, $urandom_range(2), $urandom_range(1));
      end else if (kind < 88) begin
        queue_noise(16);
      end else begin
        slip = $urandom_range(1, 15);
        queue_noise(slip);
        queue_frame(range_val, str, NoFault, 1'b0);
        queue_frame(24'($urandom), 16'($urandom), NoFault, 1'b0);
        queue_noise(16 - slip);
      end
    end
  endtask

  // Returns once every queued byte has been taken and every result has come.
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || rx_valid) @(posedge clk);
    while (frame_expect.size() != 0) @(posedge clk);
  endtask

  // Sender: a new byte is offered only when none is pending or the pending
  // one is taken at this edge, so valid and data hold steady until accepted.
  always @(posedge clk) begin
    if (rst) begin
      rx_valid <= 1'b0;
      rx_byte <= 8'h00;
    end else if (!rx_valid || rx_ready) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= feed_idle_pct) begin
        rx_valid <= 1'b1;
        rx_byte <= pending_bytes.pop_front();
      end else begin
        rx_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off that lets the
  // block fill up and push back on the sender.
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_start && !hold_done) begin
      res_ready <= 1'b0;
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      res_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      res_ready <= ($urandom_range(99) >= drain_idle_pct);
    end
  end

  // Monitor: feeds accepted bytes to the frame model and compares each
  // accepted result with the oldest expected one. Both handshakes are
  // sampled at the edge, before any driver update lands.
  always @(posedge clk) begin
    frame_result_t want;
    if (!rst) begin
      if (rx_valid && rx_ready) absorb_byte(rx_byte);
      if (res_valid && res_ready) begin
        if (frame_expect.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: status %0d distance %h strength %h",
                     frame_status, distance_mm, signal_strength);
        end else begin
          want = frame_expect.pop_front();
          if (frame_status != want.status || distance_mm != want.distance ||
              signal_strength != want.strength) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result mismatch: expected status %0d distance %h strength %h, got %0d %h %h",
                       want.status, want.distance, want.strength,
                       frame_status, distance_mm, signal_strength);
          end
        end
      end
    end
  end

  // Watchdog: ends the run if no item moves on either side for too long.
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else if ((rx_valid && rx_ready) || (res_valid && res_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("tof_uart_frame_checker_top: mismatch");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed frames, sent while the sender idles lightly and the receiver
    // often stalls. Plain valid frames at the field extremes come first.
    queue_frame(24'h000001, 16'h0001, NoFault, 1'b0);
    queue_frame(24'hFFFFFF, 16'hFFFF, NoFault, 1'b0);
    queue_frame(24'h000000, 16'hFFFF, NoFault, 1'b0);
    queue_frame(24'hFFFFF5, 16'h8000, NoFault, 1'b0);
    queue_frame(24'hFFFFF7, 16'h0100, NoFault, 1'b0);
    // No signal: zero strength, out-of-range distance, and both together.
    queue_frame(24'h001234, 16'h0000, NoFault, 1'b0);
    queue_frame(OutOfRange, 16'h0042, NoFault, 1'b0);
    queue_frame(OutOfRange, 16'h0000, NoFault, 1'b0);
    // A broken header at each of its three bytes, then a bad checksum.
    queue_frame(24'h00ABCD, 16'h1111, 0, 1'b0);
    queue_frame(24'h00ABCD, 16'h2222, 1, 1'b0);
    queue_frame(24'h00ABCD, 16'h3333, 2, 1'b0);
    queue_frame(24'h00ABCD, 16'h4444, NoFault, 1'b1);
    // Errors take precedence over the no-signal status.
    queue_frame(24'h000777, 16'h0000, NoFault, 1'b1);
    queue_frame(OutOfRange, 16'h5555, 1, 1'b0);
    // Frames of all zeros and all ones.
    queue_fill(8'h00, 16);
    queue_fill(8'hFF, 16);
    // A stream that starts mid-frame keeps failing until it realigns.
    queue_noise(5);
    queue_frame(24'h000100, 16'h0200, NoFault, 1'b0);
    queue_frame(24'h000300, 16'h0400, NoFault, 1'b0);
    queue_noise(11);
    queue_frame(24'h000500, 16'h0600, NoFault, 1'b0);

    queue_random_frames(PhaseBytes);
    wait_drained();

    // The sender now idles more than the receiver.
    feed_idle_pct <= 52;
    drain_idle_pct <= 24;
    @(posedge clk);
    queue_random_frames(PhaseBytes);
    wait_drained();

    // Neither side idles; the receiver starts with its long hold-off while
    // the sender keeps offering bytes, so the block has to stall its input.
    feed_idle_pct <= 0;
    drain_idle_pct <= 0;
    hold_start <= 1'b1;
    @(posedge clk);
    queue_random_frames(PhaseBytes);
    wait_drained();

    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tof_uart_frame_checker_top: match");
    end else begin
      $display("tof_uart_frame_checker_top: mismatch");
    end
    $finish;
  end

endmodule
